### rtl/core/kcme_pkg.sv
// Shared types and constants for the key change to MIDI events core.
// No dependencies; every other file of the core refers to it by scoped names.

package kcme_pkg;

   localparam int KEYS_PER_BANK = 8;
   localparam int BANKS         = 3;
   localparam int BANK_WIDTH    = 8;
   localparam int SCAN_WIDTH    = BANKS * BANK_WIDTH;
   localparam int QUEUE_DEPTH   = 2;

   localparam int NOTE_WIDTH    = 7;
   localparam int CHAN_WIDTH    = 4;
   localparam int CSR_IDX_WIDTH = 3;
   localparam int CSR_WIDTH     = 7;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BANK0_BASE = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BANK1_BASE = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BANK2_BASE = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CHANNEL    = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_VELOCITY   = 3'd4;

   // Reset values of the registers.
   localparam logic [NOTE_WIDTH-1:0] BANK0_BASE_RESET = 7'd36;
   localparam logic [NOTE_WIDTH-1:0] BANK1_BASE_RESET = 7'd44;
   localparam logic [NOTE_WIDTH-1:0] BANK2_BASE_RESET = 7'd52;
   localparam logic [CHAN_WIDTH-1:0] CHANNEL_RESET    = 4'd7;
   localparam logic [NOTE_WIDTH-1:0] VELOCITY_RESET   = 7'h7F;

   // Upper nibbles of the status byte.
   localparam logic [3:0] NOTE_ON_NIBBLE  = 4'h9;
   localparam logic [3:0] NOTE_OFF_NIBBLE = 4'h8;
   localparam logic [NOTE_WIDTH-1:0] RELEASE_VELOCITY = 7'h00;

   typedef struct packed {
      logic [NOTE_WIDTH-1:0] bank0_base;
      logic [NOTE_WIDTH-1:0] bank1_base;
      logic [NOTE_WIDTH-1:0] bank2_base;
      logic [CHAN_WIDTH-1:0] channel;
      logic [NOTE_WIDTH-1:0] velocity;
   } cfg_type;

   // One scan waiting for the event generator: its levels and the keys that changed.
   typedef struct packed {
      logic [SCAN_WIDTH-1:0] levels;
      logic [SCAN_WIDTH-1:0] changed;
   } job_type;

endpackage

### rtl/core/kcme_if.sv
// Stream interfaces for the scan input and the MIDI event output channels.
// Depends on kcme_pkg for the field widths.

interface kcme_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [kcme_pkg::BANK_WIDTH-1:0]        bank0_levels;
   logic [kcme_pkg::BANK_WIDTH-1:0]        bank1_levels;
   logic [kcme_pkg::BANK_WIDTH-1:0]        bank2_levels;

   modport source (output valid, output bank0_levels, output bank1_levels,
                   output bank2_levels, input ready);
   modport sink   (input valid, input bank0_levels, input bank1_levels,
                   input bank2_levels, output ready);
endinterface

interface kcme_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [7:0]                             status_byte;
   logic [kcme_pkg::NOTE_WIDTH-1:0]        note_number;
   logic [kcme_pkg::NOTE_WIDTH-1:0]        velocity;
   logic                                   last_event;

   modport source (output valid, output status_byte, output note_number,
                   output velocity, output last_event, input ready);
   modport sink   (input valid, input status_byte, input note_number,
                   input velocity, input last_event, output ready);
endinterface

### rtl/core/kcme_front.sv
// Front end: accepts key scans, finds the keys that changed and queues a job.
// Depends on kcme_pkg and kcme_req_if.

module kcme_front #(
   parameter int KEYS_PER_BANK = kcme_pkg::KEYS_PER_BANK
) (
   input  logic               clock,
   input  logic               reset,
   kcme_req_if.sink           req_if,
   output logic               push_valid,
   output kcme_pkg::job_type  push_job,
   input  logic               queue_full
);

   localparam logic [kcme_pkg::BANK_WIDTH-1:0] KEY_MASK =
      kcme_pkg::BANK_WIDTH'((1 << KEYS_PER_BANK) - 1);

   logic [kcme_pkg::SCAN_WIDTH-1:0] prev_ff, prev_in;
   logic [kcme_pkg::SCAN_WIDTH-1:0] scan;
   logic [kcme_pkg::SCAN_WIDTH-1:0] changed;
   logic                            accept;

   assign scan    = {req_if.bank2_levels, req_if.bank1_levels, req_if.bank0_levels};
   // Bits above the keys in use are stored but never report a change.
   assign changed = (scan ^ prev_ff) & {KEY_MASK, KEY_MASK, KEY_MASK};

   assign req_if.ready = !queue_full;
   assign accept       = req_if.valid && !queue_full;

   assign push_valid     = accept && (changed != '0);
   assign push_job.levels  = scan;
   assign push_job.changed = changed;

   assign prev_in = accept ? scan : prev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '1;
      end else begin
         prev_ff <= prev_in;
      end
   end

endmodule

### rtl/core/kcme_queue.sv
// Short queue of pending scan jobs between the front and back ends.
// Depends on kcme_pkg for the job type and the depth.

module kcme_queue #(
   parameter int DEPTH = kcme_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  kcme_pkg::job_type  push_job,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output kcme_pkg::job_type  head
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   kcme_pkg::job_type         slot_ff [DEPTH];
   logic [PTR_WIDTH-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]      count_ff, count_in;
   logic                      do_push, do_pop;

   assign full  = (count_ff == CNT_WIDTH'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   assign do_push = push_valid && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_WIDTH'(do_push) - CNT_WIDTH'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### rtl/core/kcme_back.sv
// Back end: walks the changed keys of one job and emits one MIDI event per cycle while the output is not stalled.
// Depends on kcme_pkg and kcme_rsp_if.

module kcme_back #(
   parameter int KEYS_PER_BANK = kcme_pkg::KEYS_PER_BANK
) (
   input  logic               clock,
   input  logic               reset,
   input  kcme_pkg::cfg_type  cfg,
   input  logic               queue_empty,
   input  kcme_pkg::job_type  queue_head,
   output logic               queue_pop,
   kcme_rsp_if.source         rsp_if
);

   localparam int IDX_WIDTH = $clog2(kcme_pkg::SCAN_WIDTH);
   localparam logic [kcme_pkg::NOTE_WIDTH-1:0] BASE_LIMIT =
      kcme_pkg::NOTE_WIDTH'(128 - KEYS_PER_BANK);

   logic [kcme_pkg::SCAN_WIDTH-1:0] mask_ff, mask_in;
   logic [kcme_pkg::SCAN_WIDTH-1:0] levels_ff, levels_in;
   logic [kcme_pkg::SCAN_WIDTH-1:0] lowest, rest;
   logic [IDX_WIDTH-1:0]            idx;
   logic [kcme_pkg::NOTE_WIDTH-1:0] base, base_lim;
   logic                            pressed, emit;

   logic                            valid_ff, valid_in;
   logic [7:0]                      status_ff, status_in;
   logic [kcme_pkg::NOTE_WIDTH-1:0] note_ff, note_in;
   logic [kcme_pkg::NOTE_WIDTH-1:0] vel_ff, vel_in;
   logic                            last_ff, last_in;

   // Isolate the lowest pending key and encode its position.
   assign lowest = mask_ff & (~mask_ff + 1'b1);
   assign rest   = mask_ff & ~lowest;

   always_comb begin
      idx = '0;
      for (int j = 0; j < kcme_pkg::SCAN_WIDTH; j++) begin
         if (lowest[j]) begin
            idx = idx | IDX_WIDTH'(j);
         end
      end
   end

   always_comb begin
      case (idx[IDX_WIDTH-1:3])
         2'd0:    base = cfg.bank0_base;
         2'd1:    base = cfg.bank1_base;
         2'd2:    base = cfg.bank2_base;
         default: base = cfg.bank0_base;
      endcase
      base_lim = (base > BASE_LIMIT) ? BASE_LIMIT : base;
   end

   assign pressed   = ((levels_ff & lowest) == '0);
   assign emit      = (mask_ff != '0) && (!valid_ff || rsp_if.ready);
   assign queue_pop = (mask_ff == '0) && !queue_empty;

   always_comb begin
      mask_in   = mask_ff;
      levels_in = levels_ff;
      if (queue_pop) begin
         mask_in   = queue_head.changed;
         levels_in = queue_head.levels;
      end else if (emit) begin
         mask_in = rest;
      end
   end

   always_comb begin
      valid_in  = valid_ff;
      status_in = status_ff;
      note_in   = note_ff;
      vel_in    = vel_ff;
      last_in   = last_ff;
      if (emit) begin
         valid_in  = 1'b1;
         status_in = {pressed ? kcme_pkg::NOTE_ON_NIBBLE : kcme_pkg::NOTE_OFF_NIBBLE,
                      cfg.channel};
         note_in   = base_lim + kcme_pkg::NOTE_WIDTH'(idx[2:0]);
         vel_in    = pressed ? cfg.velocity : kcme_pkg::RELEASE_VELOCITY;
         last_in   = (rest == '0);
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         mask_ff  <= mask_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      levels_ff <= levels_in;
      status_ff <= status_in;
      note_ff   <= note_in;
      vel_ff    <= vel_in;
      last_ff   <= last_in;
   end

   assign rsp_if.valid       = valid_ff;
   assign rsp_if.status_byte = status_ff;
   assign rsp_if.note_number = note_ff;
   assign rsp_if.velocity    = vel_ff;
   assign rsp_if.last_event  = last_ff;

endmodule

### rtl/core/key_change_to_midi_events_core.sv
// Top level of the key change to MIDI events core: configuration registers,
// front end, job queue and event generator. Depends on kcme_pkg, the stream
// interfaces, kcme_front, kcme_queue and kcme_back.
//
//   Channel  Direction  Handshake          Transfer
//   req_if   in         valid / ready      one scan of three 8-bit key banks
//   rsp_if   out        valid / ready      one MIDI event (status, note, velocity, last)
//   csr_*    in         csr_we, no ready   one register write by index
//
// A scan is taken whenever the job queue has room; the front end
// compares it with the previous scan and queues the changed keys.
// The event generator loads a job and then emits one event per cycle per changed
// key while the output is not stalled; it loads the next job only once every
// event of the current one is emitted.
// Reset is synchronous and active high; it marks every key released and
// restores the register defaults.
// A stalled output holds its event; the queue lets further scans in meanwhile until it is full.

module key_change_to_midi_events_core #(
   parameter int KEYS_PER_BANK = kcme_pkg::KEYS_PER_BANK
) (
   input  logic                                 clock,
   input  logic                                 reset,
   kcme_req_if.sink                             req_if,
   kcme_rsp_if.source                           rsp_if,
   input  logic                                 csr_we,
   input  logic [kcme_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [kcme_pkg::CSR_WIDTH-1:0]       csr_wdata
);

   kcme_pkg::cfg_type  cfg_ff, cfg_in;
   kcme_pkg::job_type  push_job, head_job;
   logic               push_valid, queue_full, queue_empty, queue_pop;

   // Register writes; an index beyond the list is ignored and wider data is cut.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            kcme_pkg::CSR_BANK0_BASE: cfg_in.bank0_base = csr_wdata;
            kcme_pkg::CSR_BANK1_BASE: cfg_in.bank1_base = csr_wdata;
            kcme_pkg::CSR_BANK2_BASE: cfg_in.bank2_base = csr_wdata;
            kcme_pkg::CSR_CHANNEL:    cfg_in.channel    = csr_wdata[kcme_pkg::CHAN_WIDTH-1:0];
            kcme_pkg::CSR_VELOCITY:   cfg_in.velocity   = csr_wdata;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bank0_base <= kcme_pkg::BANK0_BASE_RESET;
         cfg_ff.bank1_base <= kcme_pkg::BANK1_BASE_RESET;
         cfg_ff.bank2_base <= kcme_pkg::BANK2_BASE_RESET;
         cfg_ff.channel    <= kcme_pkg::CHANNEL_RESET;
         cfg_ff.velocity   <= kcme_pkg::VELOCITY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end only queues scans in which at least one key changed.
   kcme_front #(
      .KEYS_PER_BANK (KEYS_PER_BANK)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_job   (push_job),
      .queue_full (queue_full)
   );

   kcme_queue #(
      .DEPTH (kcme_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (queue_pop),
      .empty      (queue_empty),
      .head       (head_job)
   );

   // Registers feed the back end live; the user must change them only while idle, unchecked.
   kcme_back #(
      .KEYS_PER_BANK (KEYS_PER_BANK)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .queue_head  (head_job),
      .queue_pop   (queue_pop),
      .rsp_if      (rsp_if)
   );

endmodule

### rtl/core/kcme_checker.sv
// Port-level checks of the key change to MIDI events core, bound to its top.
// Depends on kcme_pkg and key_change_to_midi_events_core.

module kcme_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [7:0]                         rsp_status_byte,
   input logic [kcme_pkg::NOTE_WIDTH-1:0]    rsp_note_number,
   input logic [kcme_pkg::NOTE_WIDTH-1:0]    rsp_velocity,
   input logic                               rsp_last_event
);

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("event offered right after reset");

   // A stalled event is held unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status_byte)
         && $stable(rsp_note_number) && $stable(rsp_velocity) && $stable(rsp_last_event))
      else $error("stalled event changed");

   // Only note on and note off status bytes are produced.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status_byte[7:4] == kcme_pkg::NOTE_ON_NIBBLE)
                 || (rsp_status_byte[7:4] == kcme_pkg::NOTE_OFF_NIBBLE))
      else $error("bad status byte");

   // A note off always carries zero velocity.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status_byte[7:4] == kcme_pkg::NOTE_OFF_NIBBLE)
         |-> rsp_velocity == kcme_pkg::RELEASE_VELOCITY)
      else $error("note off with non-zero velocity");

endmodule

bind key_change_to_midi_events_core kcme_checker u_kcme_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_status_byte (rsp_if.status_byte),
   .rsp_note_number (rsp_if.note_number),
   .rsp_velocity    (rsp_if.velocity),
   .rsp_last_event  (rsp_if.last_event)
);
